// ----- rtl/best_fit_block_allocator_core_macros.svh -----
// Assertion macros for the allocator core
`ifndef BEST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// check a property on clk_i, off while rst_ni is low
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check an implication on clk_i, off while rst_ni is low
`define BFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/bfa_pkg.sv -----
// Shared types and constants for the best-fit block allocator
package bfa_pkg;

  localparam int unsigned MAX_UNITS      = 1024;
  localparam int unsigned IDX_W          = $clog2(MAX_UNITS);
  localparam int unsigned LEN_W          = IDX_W + 1;
  localparam int unsigned HEADER_BYTES   = 16;
  localparam int unsigned UNIT_ALIGN     = 8;
  localparam int unsigned MIN_UNIT_BYTES = 10 * UNIT_ALIGN;
  localparam int unsigned REQ_W          = 24;
  localparam int unsigned UB_W           = 17;
  localparam int unsigned CFG_W          = 16;

  localparam logic       CFG_UNIT_BYTES  = 1'b0;
  localparam logic       CFG_ARENA_UNITS = 1'b1;

  localparam logic [2:0] ST_ALLOC    = 3'd0;
  localparam logic [2:0] ST_NOMEM    = 3'd1;
  localparam logic [2:0] ST_FREED    = 3'd2;
  localparam logic [2:0] ST_DUPFREE  = 3'd3;
  localparam logic [2:0] ST_BADADDR  = 3'd4;

  typedef struct packed {
    logic             head;
    logic             free;
    logic [LEN_W-1:0] len;
  } ent_t;

  typedef struct packed {
    logic             done;
    logic [REQ_W-1:0] quot;
    logic [UB_W-1:0]  rem;
  } div_res_t;

endpackage

// ----- rtl/best_fit_block_allocator_core.sv -----
// Best-fit block allocator core: top level with block table memory
// Allocate runs the unit divider, then walks the block table one entry per cycle;
//   free reads the block and its right neighbour, then walks the blocks before it.
// Throughput: one word at a time; a new word is taken only once the last result has
//   been loaded into the output register.
// Reset and any arena_units write run a clearing pass over all MAX_UNITS (1024)
//   block table entries; no input word is taken during the pass.
module best_fit_block_allocator_core import bfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             in_mode_i,
  input  logic [REQ_W-1:0] in_request_bytes_i,
  input  logic [IDX_W-1:0] in_block_start_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       out_status_o,
  output logic [IDX_W-1:0] out_grant_start_o,
  output logic [LEN_W-1:0] out_grant_units_o,
  output logic [LEN_W-1:0] out_free_units_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_AWALK, S_AFIN, S_AW2,
    S_FB, S_FR, S_FWALK, S_FFIN, S_FW2, S_DONE
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] unit_bytes_q;
  logic [LEN_W-1:0] arena_len_q;
  logic [LEN_W-1:0] free_total_q;
  logic [IDX_W-1:0] clr_idx_q;
  logic [IDX_W-1:0] cur_q;
  logic [LEN_W-1:0] n_q;
  logic             found_q;
  logic [IDX_W-1:0] best_q;
  logic [LEN_W-1:0] best_len_q;
  logic [LEN_W-1:0] grant_q;
  logic [IDX_W-1:0] blk_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] total_q;
  logic [IDX_W+1:0] right_q;
  logic             have_prev_q;
  logic [IDX_W-1:0] prev_q;
  ent_t             prev_ent_q;
  logic [IDX_W+1:0] u_q;
  logic [2:0]       res_status_q;
  logic [IDX_W-1:0] res_start_q;
  logic [LEN_W-1:0] res_units_q;
  logic             out_valid_q;
  logic [2:0]       out_status_q;
  logic [IDX_W-1:0] out_start_q;
  logic [LEN_W-1:0] out_units_q;
  logic [LEN_W-1:0] out_free_q;

  ent_t             mem [MAX_UNITS];
  ent_t             rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ent_t             mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  logic [UB_W-1:0]  eff_ub;
  logic [UB_W-1:0]  ub_floor;
  logic             div_start;
  div_res_t         div_res;
  logic             rem_nz;
  logic             hdr_extra;
  logic [REQ_W:0]   n_full;
  logic [IDX_W+1:0] walk_next;
  logic [IDX_W+1:0] right_c;
  logic             cand;
  logic             split;
  logic             in_acc;
  logic [LEN_W-1:0] arena_clamp;
  logic [LEN_W-1:0] cfg_arena;
  logic             arena_we;
  logic             out_load;

  assign ub_floor  = (unit_bytes_q < CFG_W'(MIN_UNIT_BYTES)) ? UB_W'(MIN_UNIT_BYTES)
                                                            : {1'b0, unit_bytes_q};
  assign eff_ub    = (ub_floor + UB_W'(UNIT_ALIGN - 1)) & ~UB_W'(UNIT_ALIGN - 1);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign div_start = in_acc && !in_mode_i;

  bfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_request_bytes_i),
    .divisor_i  (eff_ub),
    .res_o      (div_res)
  );

  assign rem_nz    = div_res.rem != '0;
  assign hdr_extra = !rem_nz || (({1'b0, div_res.rem} + (UB_W+1)'(HEADER_BYTES))
                                 >= {1'b0, eff_ub});
  assign n_full    = {1'b0, div_res.quot} + (REQ_W+1)'(rem_nz) + (REQ_W+1)'(hdr_extra);

  assign walk_next = {2'b00, cur_q} + {1'b0, rdata_q.len};
  assign right_c   = {2'b00, blk_q} + {1'b0, rdata_q.len};
  assign cand      = rdata_q.free && (rdata_q.len >= n_q)
                     && (!found_q || (rdata_q.len < best_len_q));
  assign split     = {1'b0, best_len_q} > ({1'b0, n_q} + (LEN_W+1)'(1));

  assign cfg_arena   = cfg_data_i[LEN_W-1:0];
  assign arena_clamp = (cfg_arena < LEN_W'(2)) ? LEN_W'(2)
                     : (cfg_arena > LEN_W'(MAX_UNITS)) ? LEN_W'(MAX_UNITS) : cfg_arena;

  assign arena_we = cfg_we_i && (cfg_idx_i == CFG_ARENA_UNITS);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i) && !arena_we;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = blk_q;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        if (clr_idx_q == '0) begin
          mem_wdata = '{head: 1'b1, free: 1'b1, len: arena_len_q};
        end
      end
      S_IDLE: mem_raddr = in_mode_i ? in_block_start_i : '0;
      S_AWALK: mem_raddr = walk_next[IDX_W-1:0];
      S_AFIN: begin
        if (found_q && split) begin
          mem_we    = 1'b1;
          mem_waddr = best_q + n_q[IDX_W-1:0];
          mem_wdata = '{head: 1'b1, free: 1'b1, len: best_len_q - n_q};
        end
      end
      S_AW2: begin
        mem_we    = 1'b1;
        mem_waddr = best_q;
        mem_wdata = '{head: 1'b1, free: 1'b0, len: grant_q};
      end
      S_FB: mem_raddr = (right_c < {1'b0, arena_len_q}) ? right_c[IDX_W-1:0] : '0;
      S_FR: begin
        if (rdata_q.head && rdata_q.free) begin
          mem_we    = 1'b1;
          mem_waddr = right_q[IDX_W-1:0];
        end
      end
      S_FWALK: mem_raddr = walk_next[IDX_W-1:0];
      S_FFIN: begin
        mem_we = 1'b1;
        if (have_prev_q && (u_q == {2'b00, blk_q}) && prev_ent_q.free) begin
          mem_waddr = prev_q;
          mem_wdata = '{head: 1'b1, free: 1'b1, len: prev_ent_q.len + total_q};
        end else begin
          mem_waddr = blk_q;
          mem_wdata = '{head: 1'b1, free: 1'b1, len: total_q};
        end
      end
      S_FW2: begin
        mem_we    = 1'b1;
        mem_waddr = blk_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      unit_bytes_q <= CFG_W'(MIN_UNIT_BYTES);
      arena_len_q  <= LEN_W'(MAX_UNITS);
      free_total_q <= LEN_W'(MAX_UNITS);
      clr_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      have_prev_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_UNIT_BYTES)) begin
        unit_bytes_q <= cfg_data_i;
      end
      if (arena_we) begin
        arena_len_q  <= arena_clamp;
        free_total_q <= arena_clamp;
        clr_idx_q    <= '0;
        state_q      <= S_CLR;
      end else begin
        case (state_q)
          S_CLR: begin
            clr_idx_q <= clr_idx_q + 1'b1;
            if (clr_idx_q == IDX_W'(MAX_UNITS - 1)) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              blk_q       <= in_block_start_i;
              have_prev_q <= 1'b0;
              found_q     <= 1'b0;
              cur_q       <= '0;
              res_start_q <= '0;
              res_units_q <= '0;
              if (!in_mode_i) begin
                state_q <= S_DIV;
              end else if ({1'b0, in_block_start_i} >= arena_len_q) begin
                res_status_q <= ST_BADADDR;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_FB;
              end
            end
          end
          S_DIV: begin
            if (div_res.done) begin
              if (n_full > (REQ_W+1)'(free_total_q)) begin
                res_status_q <= ST_NOMEM;
                state_q      <= S_DONE;
              end else begin
                n_q     <= n_full[LEN_W-1:0];
                state_q <= S_AWALK;
              end
            end
          end
          S_AWALK: begin
            if (cand) begin
              found_q    <= 1'b1;
              best_q     <= cur_q;
              best_len_q <= rdata_q.len;
            end
            cur_q <= walk_next[IDX_W-1:0];
            if ((rdata_q.len == '0) || (walk_next >= {1'b0, arena_len_q})) begin
              state_q <= S_AFIN;
            end
          end
          S_AFIN: begin
            if (!found_q) begin
              res_status_q <= ST_NOMEM;
              state_q      <= S_DONE;
            end else begin
              grant_q <= split ? n_q : best_len_q;
              state_q <= S_AW2;
            end
          end
          S_AW2: begin
            free_total_q <= free_total_q - grant_q;
            res_status_q <= ST_ALLOC;
            res_start_q  <= best_q;
            res_units_q  <= grant_q;
            state_q      <= S_DONE;
          end
          S_FB: begin
            if (!rdata_q.head) begin
              res_status_q <= ST_BADADDR;
              state_q      <= S_DONE;
            end else if (rdata_q.free) begin
              res_status_q <= ST_DUPFREE;
              res_start_q  <= blk_q;
              state_q      <= S_DONE;
            end else begin
              len_q        <= rdata_q.len;
              total_q      <= rdata_q.len;
              free_total_q <= free_total_q + rdata_q.len;
              right_q      <= right_c;
              if (right_c < {1'b0, arena_len_q}) begin
                state_q <= S_FR;
              end else if (blk_q == '0) begin
                state_q <= S_FFIN;
              end else begin
                state_q <= S_FWALK;
              end
            end
          end
          S_FR: begin
            if (rdata_q.head && rdata_q.free) begin
              total_q <= total_q + rdata_q.len;
            end
            state_q <= (blk_q == '0) ? S_FFIN : S_FWALK;
          end
          S_FWALK: begin
            if (rdata_q.len == '0) begin
              state_q <= S_FFIN;
            end else begin
              prev_q      <= cur_q;
              prev_ent_q  <= rdata_q;
              have_prev_q <= 1'b1;
              u_q         <= walk_next;
              cur_q       <= walk_next[IDX_W-1:0];
              if (walk_next >= {2'b00, blk_q}) begin
                state_q <= S_FFIN;
              end
            end
          end
          S_FFIN: begin
            res_status_q <= ST_FREED;
            res_start_q  <= blk_q;
            res_units_q  <= len_q;
            if (have_prev_q && (u_q == {2'b00, blk_q}) && prev_ent_q.free) begin
              state_q <= S_FW2;
            end else begin
              state_q <= S_DONE;
            end
          end
          S_FW2: state_q <= S_DONE;
          S_DONE: begin
            if (out_load) begin
              out_status_q <= res_status_q;
              out_start_q  <= res_start_q;
              out_units_q  <= res_units_q;
              out_free_q   <= free_total_q;
              state_q      <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_grant_start_o = out_start_q;
  assign out_grant_units_o = out_units_q;
  assign out_free_units_o  = out_free_q;

`include "best_fit_block_allocator_core_macros.svh"

  `BFA_ASSERT(a_free_le_arena, free_total_q <= arena_len_q, "free total exceeds arena")
  `BFA_ASSERT_IMP(a_walk_in_arena, state_q == S_AWALK || state_q == S_FWALK, {1'b0, cur_q} < arena_len_q, "walk left the arena")
  `BFA_ASSERT_IMP(a_grant_nonzero, out_valid_q && out_status_q == ST_ALLOC, out_units_q != '0, "allocation granted zero units")

endmodule

// ----- rtl/bfa_div.sv -----
// Restoring divider, one quotient bit per cycle
module bfa_div import bfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [REQ_W-1:0] dividend_i,
  input  logic [UB_W-1:0]  divisor_i,
  output div_res_t         res_o
);

  localparam int unsigned CNT_W = $clog2(REQ_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REQ_W-1:0] quot_q;
  logic [UB_W:0]    rem_q;
  logic [UB_W-1:0]  dsr_q;
  logic             done_q;
  logic [UB_W:0]    shifted;
  logic             fits;

  assign shifted = {rem_q[UB_W-1:0], quot_q[REQ_W-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(REQ_W);
        quot_q <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q  <= fits ? (shifted - {1'b0, dsr_q}) : shifted;
        quot_q <= {quot_q[REQ_W-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q[UB_W-1:0];

endmodule

// ----- sim/tb_best_fit_block_allocator_core.sv -----
// Self-checking testbench for the best-fit block allocator core
module tb_best_fit_block_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 96;
  localparam int unsigned N_ROWS = 14;

  typedef struct packed {
    logic [2:0]       st;
    logic [IDX_W-1:0] gs;
    logic [LEN_W-1:0] gu;
    logic [LEN_W-1:0] fu;
  } res_t;

  typedef struct packed {
    logic             mode;
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] start;
    logic             chk;
    res_t             res;
  } row_t;

  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{1'b0, 24'd0,        10'd0,    1'b1, '{ST_ALLOC,   10'd0,    11'd1, 11'd1023}},
    '{1'b0, 24'd64,       10'd0,    1'b1, '{ST_ALLOC,   10'd1,    11'd2, 11'd1021}},
    '{1'b0, 24'd63,       10'd0,    1'b1, '{ST_ALLOC,   10'd3,    11'd1, 11'd1020}},
    '{1'b1, 24'd0,        10'd1,    1'b1, '{ST_FREED,   10'd1,    11'd2, 11'd1022}},
    '{1'b1, 24'd0,        10'd1,    1'b1, '{ST_DUPFREE, 10'd1,    11'd0, 11'd1022}},
    '{1'b1, 24'd0,        10'd2,    1'b1, '{ST_BADADDR, 10'd0,    11'd0, 11'd1022}},
    '{1'b1, 24'd0,        10'd1023, 1'b1, '{ST_BADADDR, 10'd0,    11'd0, 11'd1022}},
    '{1'b0, 24'hFFFFFF,   10'd0,    1'b1, '{ST_NOMEM,   10'd0,    11'd0, 11'd1022}},
    '{1'b0, 24'd80,       10'd0,    1'b1, '{ST_ALLOC,   10'd1,    11'd2, 11'd1020}},
    '{1'b0, 24'd0,        10'd0,    1'b1, '{ST_ALLOC,   10'd4,    11'd1, 11'd1019}},
    '{1'b1, 24'd0,        10'd3,    1'b0, '0},
    '{1'b1, 24'd0,        10'd0,    1'b0, '0},
    '{1'b1, 24'd0,        10'd1,    1'b0, '0},
    '{1'b1, 24'd0,        10'd4,    1'b0, '0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             in_mode_i = 1'b0;
  logic [REQ_W-1:0] in_request_bytes_i = '0;
  logic [IDX_W-1:0] in_block_start_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [2:0]       out_status_o;
  logic [IDX_W-1:0] out_grant_start_o;
  logic [LEN_W-1:0] out_grant_units_o;
  logic [LEN_W-1:0] out_free_units_o;

  best_fit_block_allocator_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned seg_len [MAX_UNITS];
  bit          seg_head [MAX_UNITS];
  bit          seg_free [MAX_UNITS];
  int unsigned free_cnt, arena_sz, unit_cfg, arena_cfg;
  int unsigned live_q [$];
  res_t        pending_q [$];
  int unsigned err_cnt = 0, word_cnt = 0, result_cnt = 0, cycle_cnt = 0;
  int unsigned nomem_cnt = 0, bad_cnt = 0;
  bit          calm = 1'b0;

  function automatic void arena_reset();
    arena_sz = arena_cfg < 2 ? 2 : (arena_cfg > MAX_UNITS ? MAX_UNITS : arena_cfg);
    for (int i = 0; i < MAX_UNITS; i++) begin
      seg_len[i] = 0;
      seg_head[i] = 1'b0;
      seg_free[i] = 1'b0;
    end
    seg_head[0] = 1'b1;
    seg_free[0] = 1'b1;
    seg_len[0] = arena_sz;
    free_cnt = arena_sz;
    live_q.delete();
  endfunction

  function automatic int unsigned unit_size();
    int unsigned u;
    u = unit_cfg < MIN_UNIT_BYTES ? MIN_UNIT_BYTES : unit_cfg;
    return (u + UNIT_ALIGN - 1) & ~(UNIT_ALIGN - 1);
  endfunction

  function automatic res_t alloc_predict(int unsigned req);
    int unsigned ub, n, u, best, best_len, rem;
    bit found;
    res_t r;
    ub = unit_size();
    n = req / ub;
    u = 0;
    best = 0;
    best_len = 0;
    found = 1'b0;
    if (n * ub < req) n++;
    if (req + HEADER_BYTES >= n * ub) n++;
    r = '{ST_NOMEM, '0, '0, free_cnt[LEN_W-1:0]};
    if (n > free_cnt) return r;
    while (u < arena_sz && seg_len[u] != 0) begin
      if (seg_free[u] && seg_len[u] >= n && (!found || seg_len[u] < best_len)) begin
        found = 1'b1;
        best = u;
        best_len = seg_len[u];
      end
      u += seg_len[u];
    end
    if (!found) return r;
    if (best_len > n + 1) begin
      rem = best + n;
      seg_head[rem] = 1'b1;
      seg_free[rem] = 1'b1;
      seg_len[rem] = best_len - n;
      seg_len[best] = n;
      best_len = n;
    end
    seg_free[best] = 1'b0;
    free_cnt -= best_len;
    live_q.push_back(best);
    r = '{ST_ALLOC, best[IDX_W-1:0], best_len[LEN_W-1:0], free_cnt[LEN_W-1:0]};
    return r;
  endfunction

  function automatic res_t release_predict(int unsigned b);
    int unsigned len, total, right, u, prev;
    bit have_prev;
    res_t r;
    prev = 0;
    have_prev = 1'b0;
    u = 0;
    if (b >= arena_sz || !seg_head[b]) return '{ST_BADADDR, '0, '0, free_cnt[LEN_W-1:0]};
    if (seg_free[b]) return '{ST_DUPFREE, b[IDX_W-1:0], '0, free_cnt[LEN_W-1:0]};
    len = seg_len[b];
    free_cnt += len;
    seg_free[b] = 1'b1;
    total = len;
    right = b + len;
    if (right < arena_sz && seg_head[right] && seg_free[right]) begin
      total += seg_len[right];
      seg_head[right] = 1'b0;
      seg_free[right] = 1'b0;
      seg_len[right] = 0;
    end
    while (u < b && seg_len[u] != 0) begin
      prev = u;
      have_prev = 1'b1;
      u += seg_len[u];
    end
    if (have_prev && u == b && seg_free[prev]) begin
      seg_len[prev] += total;
      seg_head[b] = 1'b0;
      seg_free[b] = 1'b0;
      seg_len[b] = 0;
    end else begin
      seg_len[b] = total;
    end
    foreach (live_q[i]) begin
      if (live_q[i] == b) begin
        live_q.delete(i);
        break;
      end
    end
    r = '{ST_FREED, b[IDX_W-1:0], len[LEN_W-1:0], free_cnt[LEN_W-1:0]};
    return r;
  endfunction

  task automatic send_word(input logic mode, input logic [REQ_W-1:0] req,
                           input logic [IDX_W-1:0] start, input bit chk, input res_t typed);
    res_t r;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_mode_i = mode;
    in_request_bytes_i = req;
    in_block_start_i = start;
    do @(posedge clk_i); while (in_stall_o);
    r = mode ? release_predict(start) : alloc_predict(req);
    if (r.st == ST_NOMEM) nomem_cnt++;
    if (r.st == ST_BADADDR || r.st == ST_DUPFREE) bad_cnt++;
    pending_q.push_back(chk ? typed : r);
    word_cnt++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_UNIT_BYTES) begin
      unit_cfg = data;
    end else begin
      arena_cfg = data & 16'h07FF;
      arena_reset();
    end
  endtask

  always @(negedge clk_i) out_stall_i = !calm && $urandom_range(99) < 34;

  always @(posedge clk_i) begin
    res_t e;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, out_status_o);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_status_o !== e.st || out_grant_start_o !== e.gs ||
            out_grant_units_o !== e.gu || out_free_units_o !== e.fu) begin
          $display("%0t: expected st %0d start %0d units %0d free %0d, got %0d %0d %0d %0d",
                   $time, e.st, e.gs, e.gu, e.fu, out_status_o, out_grant_start_o,
                   out_grant_units_o, out_free_units_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned unit_set [N_PHASES];
    int unsigned arena_set [N_PHASES];
    logic mode;
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] start;
    int unsigned ub;
    unit_set = '{80, 0, 65535, 81, 200, 8};
    arena_set = '{1024, 1, 2047, 3, 64, 1024};
    unit_cfg = 80;
    arena_cfg = 1024;
    arena_reset();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (DIR_ROWS[i])
      send_word(DIR_ROWS[i].mode, DIR_ROWS[i].req, DIR_ROWS[i].start, DIR_ROWS[i].chk,
                DIR_ROWS[i].res);
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p != 0) begin
        cfg_write(CFG_UNIT_BYTES, CFG_W'(unit_set[p]));
        cfg_write(CFG_ARENA_UNITS, CFG_W'(arena_set[p]));
      end
      calm = (p == 4);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (p == 0 && k == 40) drain();
        ub = unit_size();
        mode = $urandom_range(99) < 45;
        start = IDX_W'($urandom_range(MAX_UNITS - 1));
        if (mode && live_q.size() != 0 && $urandom_range(3) != 0)
          start = IDX_W'(live_q[$urandom_range(live_q.size() - 1)]);
        case ($urandom_range(7))
          0: req = REQ_W'($urandom);
          1: req = REQ_W'($urandom_range(1, 8) * ub - HEADER_BYTES + $urandom_range(0, 1) - 1);
          default: req = REQ_W'($urandom_range(0, 6 * ub));
        endcase
        send_word(mode, req, start, 1'b0, '0);
      end
    end
    calm = 1'b0;
    drain();
    repeat (40) @(negedge clk_i);
    $display("Covered %0d words over %0d settings: %0d results, %0d out of memory, %0d rejected",
             word_cnt, N_PHASES, result_cnt, nomem_cnt, bad_cnt);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- best_fit_block_allocator_core.f -----
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_div.sv
rtl/best_fit_block_allocator_core.sv
sim/tb_best_fit_block_allocator_core.sv
